### rtl/core/stq_pkg.sv
// Shared types, byte constants and result builders for the shell quote tokenizer.
package stq_pkg;

  typedef enum logic [2:0] {
    MODE_PLAIN = 3'd0,
    MODE_SQ    = 3'd1,
    MODE_DQ    = 3'd2,
    MODE_PESC  = 3'd3,
    MODE_DESC  = 3'd4
  } lex_mode_t;

  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_SQUOTE  = 8'h27;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_LOWER_N = 8'h6E;
  localparam logic [7:0] CH_LOWER_T = 8'h74;

  localparam int MAX_RESULTS = 3;

  // One output transfer.
  typedef struct packed {
    logic       unmatched_quote;
    logic       line_end;
    logic       word_end;
    logic       char_valid;
    logic [7:0] out_char;
    logic       last;
  } result_t;

  // All results caused by one input byte, in emission order.
  typedef struct packed {
    logic [1:0]                  cnt;
    result_t [MAX_RESULTS-1:0]   res;
  } cmd_t;

  function automatic result_t char_res(input logic [7:0] ch);
    result_t r;
    r                 = '0;
    r.out_char        = ch;
    r.char_valid      = 1'b1;
    return r;
  endfunction

  function automatic result_t mark_res(input logic we, input logic le, input logic uq);
    result_t r;
    r                 = '0;
    r.word_end        = we;
    r.line_end        = le;
    r.unmatched_quote = uq;
    return r;
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

endpackage

### rtl/core/stq_front.sv
// Front end: lexer state machine that turns each byte into a bundle of results.
module stq_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [7:0]    char_in,
  input  logic          end_of_line,
  output logic          push,
  output stq_pkg::cmd_t cmd
);
  import stq_pkg::*;

  lex_mode_t mode, mode_next;
  logic      word_nonempty, word_nonempty_next;

  lex_mode_t                 m;
  logic                      wn;
  logic                      open;
  logic [1:0]                k;
  result_t [MAX_RESULTS-1:0] res;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_PLAIN;
      word_nonempty <= 1'b0;
    end else begin
      mode          <= mode_next;
      word_nonempty <= word_nonempty_next;
    end
  end

  always_comb begin
    m    = mode;
    wn   = word_nonempty;
    k    = '0;
    res  = '0;
    open = 1'b0;

    unique case (mode)
      MODE_SQ: begin
        if (char_in == CH_SQUOTE) begin
          m = MODE_PLAIN;
        end else begin
          res[k] = char_res(char_in);
          k      = k + 2'd1;
          wn     = 1'b1;
        end
      end
      MODE_DQ: begin
        if (char_in == CH_DQUOTE) begin
          m = MODE_PLAIN;
        end else if (char_in == CH_BSLASH) begin
          m = MODE_DESC;
        end else begin
          res[k] = char_res(char_in);
          k      = k + 2'd1;
          wn     = 1'b1;
        end
      end
      MODE_DESC: begin
        // keep the backslash unless it escapes one of the three special bytes
        if (char_in != CH_BSLASH && char_in != CH_DQUOTE && char_in != CH_DOLLAR) begin
          res[k] = char_res(CH_BSLASH);
          k      = k + 2'd1;
        end
        res[k] = char_res(char_in);
        k      = k + 2'd1;
        wn     = 1'b1;
        m      = MODE_DQ;
      end
      MODE_PESC: begin
        if (char_in == CH_LOWER_T) begin
          res[k] = char_res(CH_TAB);
          k      = k + 2'd1;
        end else if (char_in == CH_LOWER_N || char_in == CH_BSLASH || char_in == CH_SPACE ||
                     char_in == CH_SQUOTE || char_in == CH_DQUOTE) begin
          res[k] = char_res(char_in);
          k      = k + 2'd1;
        end else begin
          res[k] = char_res(CH_BSLASH);
          k      = k + 2'd1;
          res[k] = char_res(char_in);
          k      = k + 2'd1;
        end
        wn = 1'b1;
        m  = MODE_PLAIN;
      end
      default: begin
        if (char_in == CH_SQUOTE) begin
          m = MODE_SQ;
        end else if (char_in == CH_DQUOTE) begin
          m = MODE_DQ;
        end else if (char_in == CH_BSLASH) begin
          m = MODE_PESC;
        end else if (is_ws(char_in)) begin
          if (wn) begin
            res[k] = mark_res(1'b1, 1'b0, 1'b0);
            k      = k + 2'd1;
            wn     = 1'b0;
          end
        end else begin
          res[k] = char_res(char_in);
          k      = k + 2'd1;
          wn     = 1'b1;
        end
      end
    endcase

    if (end_of_line) begin
      // a dangling backslash at line end is literal
      if (m == MODE_PESC || m == MODE_DESC) begin
        res[k] = char_res(CH_BSLASH);
        k      = k + 2'd1;
        wn     = 1'b1;
        m      = (m == MODE_DESC) ? MODE_DQ : MODE_PLAIN;
      end
      open   = (m == MODE_SQ) || (m == MODE_DQ);
      res[k] = mark_res(wn, 1'b1, open);
      k      = k + 2'd1;
      wn     = 1'b0;
      m      = MODE_PLAIN;
    end

    if (k != 2'd0) begin
      res[k - 2'd1].last = 1'b1;
    end

    mode_next          = accept ? m  : mode;
    word_nonempty_next = accept ? wn : word_nonempty;
    push               = accept && (k != 2'd0);
    cmd.cnt            = k;
    cmd.res            = res;
  end

endmodule

### rtl/core/stq_queue.sv
// Small register queue of per-byte result bundles between front and back.
module stq_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  stq_pkg::cmd_t push_cmd,
  input  logic          pop,
  output stq_pkg::cmd_t head,
  output logic          empty,
  output logic          full
);
  import stq_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, wr_ptr_next;
  logic [PTR_W-1:0] rd_ptr, rd_ptr_next;
  logic [CNT_W-1:0] count, count_next;

  assign empty = (count == CNT_W'(0));
  assign full  = (count == CNT_W'(DEPTH));
  assign head  = entries[rd_ptr];

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (push) begin
      wr_ptr_next = (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_next = (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
    end
    if (push && !pop) begin
      count_next = count + CNT_W'(1);
    end else if (pop && !push) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue popped while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(DEPTH))
    else $error("queue count out of range");
  a_count_grow: assert property (@(posedge clk) disable iff (rst)
      (push && !pop) |=> (count == $past(count) + CNT_W'(1)))
    else $error("queue count did not advance on push");

endmodule

### rtl/core/stq_back.sv
// Back end: walks the results of the head bundle out, one transfer per cycle while the receiver is ready.
module stq_back (
  input  logic          clk,
  input  logic          rst,
  input  stq_pkg::cmd_t head,
  input  logic          empty,
  output logic          pop,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [7:0]    m_axis_tdata,
  output logic [3:0]    m_axis_tuser,
  output logic          m_axis_tlast
);
  import stq_pkg::*;

  logic [1:0] idx, idx_next;
  result_t    cur;
  logic       xfer;

  assign cur           = head.res[idx];
  assign m_axis_tvalid = !empty;
  assign m_axis_tdata  = cur.out_char;
  assign m_axis_tuser  = {cur.unmatched_quote, cur.line_end, cur.word_end, cur.char_valid};
  assign m_axis_tlast  = cur.last;
  assign xfer          = m_axis_tvalid && m_axis_tready;
  // the final result of a bundle frees its queue slot
  assign pop           = xfer && cur.last;

  always_comb begin
    idx_next = idx;
    if (pop) begin
      idx_next = '0;
    end else if (xfer) begin
      idx_next = idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else begin
      idx <= idx_next;
    end
  end

  a_idx_in_bundle: assert property (@(posedge clk) disable iff (rst)
      m_axis_tvalid |-> (idx < head.cnt))
    else $error("result index past end of bundle");
  a_idx_restart: assert property (@(posedge clk) disable iff (rst) pop |=> (idx == 2'd0))
    else $error("result index not restarted after bundle");
  a_mark_no_char: assert property (@(posedge clk) disable iff (rst)
      (m_axis_tvalid && (cur.word_end || cur.line_end)) |-> !cur.char_valid)
    else $error("marker result carries a byte");

endmodule

### rtl/core/shell_quote_tokenizer_top.sv
// Top level of the shell quote tokenizer: lexer front, result queue, output back end.
//
// Splits a command line, one byte per input transfer, into words with shell
// quoting rules. Input: s_axis_tdata is the byte, s_axis_tlast marks the last
// byte of the line. Output: one transfer per result; m_axis_tdata is the word
// byte, m_axis_tuser flags what the transfer is (byte, end of word, end of
// line, open quote at end of line), m_axis_tlast marks the final result that
// one input byte produced. A byte may produce zero to three results.
// A byte's results are registered in the queue when the byte is taken and are
// offered once earlier results have left. Throughput: one input byte per cycle
// while the queue has room; the output side moves one result per cycle while
// m_axis_tready is high. The queue holds QUEUE_DEPTH bytes' worth of results,
// and s_axis_tready drops only when it is full.
// Reset returns the lexer to plain mode with no open word and empties the
// queue. When the receiver stalls, the current result holds on the output and
// input bytes keep being taken until the queue fills.
module shell_quote_tokenizer_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] char_in
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_char
  output logic [3:0] m_axis_tuser,   // [0] char_valid, [1] word_end, [2] line_end,
                                     // [3] unmatched_quote
  output logic       m_axis_tlast
);
  import stq_pkg::*;

  logic accept;
  logic push;
  logic pop;
  logic empty;
  logic full;
  cmd_t cmd;
  cmd_t head;

  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  stq_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .char_in     (s_axis_tdata),
    .end_of_line (s_axis_tlast),
    .push        (push),
    .cmd         (cmd)
  );

  stq_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (cmd),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  stq_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .empty         (empty),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

### tb/tb.sv
// Self-checking testbench for the shell quote tokenizer: directed lines, random lines, stalls.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import stq_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  typedef logic [7:0] byte_q_t[$];

  // One expected output transfer.
  typedef struct packed {
    logic [7:0] ch;
    logic       is_char;
    logic       word_end;
    logic       line_end;
    logic       open_quote;
    logic       last;
  } token_t;

  logic       clk           = 1'b0;
  logic       rst           = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic [7:0] s_axis_tdata  = 8'h00;
  logic       s_axis_tlast  = 1'b0;
  logic       m_axis_tready = 1'b0;
  logic       s_axis_tready;
  logic       m_axis_tvalid;
  logic [7:0] m_axis_tdata;
  logic [3:0] m_axis_tuser;
  logic       m_axis_tlast;

  // Lexer state as the tokenizer should hold it.
  lex_mode_t  lex_state  = MODE_PLAIN;
  logic       word_open  = 1'b0;
  token_t     expected_tokens[$];

  int failures     = 0;
  int tokens_seen  = 0;
  int bytes_sent   = 0;
  int cycles       = 0;
  int rx_hold      = 0;
  bit tx_idle_en   = 1'b1;
  bit rx_idle_en   = 1'b1;

  shell_quote_tokenizer_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic void push_char(input logic [7:0] ch);
    token_t t;
    t         = '0;
    t.ch      = ch;
    t.is_char = 1'b1;
    word_open = 1'b1;
    expected_tokens = {expected_tokens, t};
  endfunction

  function automatic void push_mark(input logic we, input logic le, input logic oq);
    token_t t;
    t            = '0;
    t.word_end   = we;
    t.line_end   = le;
    t.open_quote = oq;
    expected_tokens = {expected_tokens, t};
  endfunction

  // Advance the lexer by one input byte and queue the transfers it should cause.
  function automatic void split_byte(input logic [7:0] c, input logic eol);
    lex_mode_t m;
    int        first;
    m     = lex_state;
    first = expected_tokens.size();
    case (m)
      MODE_SQ: begin
        if (c == CH_SQUOTE) m = MODE_PLAIN;
        else push_char(c);
      end
      MODE_DQ: begin
        if (c == CH_DQUOTE) m = MODE_PLAIN;
        else if (c == CH_BSLASH) m = MODE_DESC;
        else push_char(c);
      end
      MODE_DESC: begin
        // keep the backslash unless it escapes one of the three special bytes
        if (c != CH_BSLASH && c != CH_DQUOTE && c != CH_DOLLAR) push_char(CH_BSLASH);
        push_char(c);
        m = MODE_DQ;
      end
      MODE_PESC: begin
        if (c == CH_LOWER_N) push_char(CH_LOWER_N);
        else if (c == CH_LOWER_T) push_char(CH_TAB);
        else if (c == CH_BSLASH || c == CH_SPACE || c == CH_SQUOTE || c == CH_DQUOTE)
          push_char(c);
        else begin
          push_char(CH_BSLASH);
          push_char(c);
        end
        m = MODE_PLAIN;
      end
      default: begin
        if (c == CH_SQUOTE) m = MODE_SQ;
        else if (c == CH_DQUOTE) m = MODE_DQ;
        else if (c == CH_BSLASH) m = MODE_PESC;
        else if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
          if (word_open) begin
            push_mark(1'b1, 1'b0, 1'b0);
            word_open = 1'b0;
          end
        end else push_char(c);
        m = (m == MODE_SQ || m == MODE_DQ || m == MODE_PESC) ? m : m;
      end
    endcase
    if (eol) begin
      // a pending backslash at the end of the line is taken literally
      if (m == MODE_PESC || m == MODE_DESC) begin
        push_char(CH_BSLASH);
        m = (m == MODE_DESC) ? MODE_DQ : MODE_PLAIN;
      end
      push_mark(word_open, 1'b1, (m == MODE_SQ || m == MODE_DQ));
      word_open = 1'b0;
      m         = MODE_PLAIN;
    end
    if (expected_tokens.size() > first)
      expected_tokens[expected_tokens.size()-1].last = 1'b1;
    lex_state = m;
  endfunction

  task automatic report_failure(input string msg);
    failures++;
    if (failures <= 10) $display("ERROR at %0t: %s", $time, msg);
  endtask

  // Predict on each input transfer, then check each output transfer.
  always @(posedge clk) begin : monitor
    token_t got;
    token_t want;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) split_byte(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1], m_axis_tuser[2],
               m_axis_tuser[3], m_axis_tlast};
        if (expected_tokens.size() == 0) begin
          report_failure($sformatf("unexpected transfer ch=%h user=%b last=%b",
                                   m_axis_tdata, m_axis_tuser, m_axis_tlast));
        end else begin
          want = expected_tokens.pop_front();
          if (got !== want)
            report_failure($sformatf({
              "transfer %0d: expected ch=%h char=%b we=%b le=%b uq=%b last=%b, ",
              "got ch=%h char=%b we=%b le=%b uq=%b last=%b"},
              tokens_seen, want.ch, want.is_char, want.word_end, want.line_end,
              want.open_quote, want.last, got.ch, got.is_char, got.word_end,
              got.line_end, got.open_quote, got.last));
        end
        tokens_seen++;
      end
    end
  end

  // Receiver: long hold-offs counted here, otherwise random stalls.
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold = rx_hold - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !rx_idle_en || ($urandom_range(0, 99) >= 37);
    end
  end

  task automatic send_byte(input logic [7:0] ch, input logic eol);
    while (tx_idle_en && $urandom_range(0, 99) < 37) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tlast  <= eol;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_line(input byte_q_t line);
    foreach (line[i]) send_byte(line[i], i == line.size() - 1);
  endtask

  task automatic send_text(input string s);
    byte_q_t q;
    for (int i = 0; i < s.len(); i++) q = {q, s[i]};
    send_line(q);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (expected_tokens.size() != 0);
  endtask

  function automatic logic [7:0] any_byte();
    case ($urandom_range(0, 9))
      0: return CH_SQUOTE;
      1: return CH_DQUOTE;
      2: return CH_BSLASH;
      3: return ($urandom_range(0, 1) != 0) ? CH_SPACE : 8'($urandom_range(9, 13));
      4: begin
        case ($urandom_range(0, 2))
          0: return CH_DOLLAR;
          1: return CH_LOWER_N;
          default: return CH_LOWER_T;
        endcase
      end
      5, 6: return 8'($urandom_range(0, 255));
      default: return 8'h61 + 8'($urandom_range(0, 25));
    endcase
  endfunction

  // Mostly well-formed words, quoted sections and escapes; some noise and cut lines.
  function automatic byte_q_t make_line();
    byte_q_t    q;
    logic [7:0] b;
    int         keep;
    repeat ($urandom_range(1, 5)) begin
      case ($urandom_range(0, 5))
        0: repeat ($urandom_range(1, 4)) q = {q, 8'h61 + 8'($urandom_range(0, 25))};
        1: begin
          q = {q, CH_SQUOTE};
          repeat ($urandom_range(0, 4)) begin
            do b = any_byte(); while (b == CH_SQUOTE);
            q = {q, b};
          end
          q = {q, CH_SQUOTE};
        end
        2: begin
          q = {q, CH_DQUOTE};
          repeat ($urandom_range(0, 4)) begin
            if ($urandom_range(0, 2) == 0) begin
              q = {q, CH_BSLASH};
              q = {q, any_byte()};
            end else begin
              do b = any_byte(); while (b == CH_DQUOTE || b == CH_BSLASH);
              q = {q, b};
            end
          end
          q = {q, CH_DQUOTE};
        end
        3: begin
          q = {q, CH_BSLASH};
          q = {q, any_byte()};
        end
        4: repeat ($urandom_range(1, 2))
             q = {q, ($urandom_range(0, 1) != 0) ? CH_SPACE : 8'($urandom_range(9, 13))};
        default: q = {q, any_byte()};
      endcase
    end
    if ($urandom_range(0, 9) == 0) begin
      keep = $urandom_range(1, q.size());
      while (q.size() > keep) void'(q.pop_back());
    end
    return q;
  endfunction

  task automatic send_random_bytes(input int count);
    int stop_at;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) send_line(make_line());
  endtask

  task automatic test_directed();
    byte_q_t q;
    send_text("x\\t\\q 'a b'");   // tab escape, kept escape, quoted space
    send_text("\"\\$\\y");        // escaped dollar, kept escape, open double quote
    send_text("''\\");            // empty quotes, then lone final backslash
    send_text("\"\\");            // lone final backslash inside double quotes
    q = '{8'h00, 8'hFF, 8'h0A};   // extreme bytes, whitespace on the marked byte
    send_line(q);
    send_text("\\n");             // escaped byte is the last of the line
  endtask

  task automatic test_random_lines();
    send_random_bytes(230);
  endtask

  task automatic test_output_hold();
    s_axis_tvalid <= 1'b0;
    tx_idle_en = 1'b0;
    @(negedge clk);
    rx_hold = 150;
    @(posedge clk);
    send_random_bytes(40);
    tx_idle_en = 1'b1;
  endtask

  task automatic test_drain_pause();
    send_random_bytes(15);
    wait_drained();
    send_random_bytes(15);
  endtask

  task automatic test_no_idle();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    send_random_bytes(60);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_lines();
    test_output_hold();
    test_drain_pause();
    test_no_idle();
    wait_drained();
    repeat (10) @(posedge clk);
    if (failures == 0 && expected_tokens.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/stq_pkg.sv
rtl/core/stq_front.sv
rtl/core/stq_queue.sv
rtl/core/stq_back.sv
rtl/core/shell_quote_tokenizer_top.sv
tb/tb.sv
